FILE: design/salc_pkg.sv
// Shared constants and types for the set-associative LRU cache classifier.
// Used by the line store and the top level; no dependencies.
package salc_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int WAY_W        = $clog2(MAX_WAYS);
    localparam int NWAY_W       = $clog2(MAX_WAYS + 1);
    localparam int LINE_AW      = MAX_SET_BITS + WAY_W;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    // access modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_FETCH  = 2'd3;

    // outcome codes of the first access
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] age;
    } line_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

FILE: design/salc_line_ram.sv
// Line store: one entry per cache line, indexed {set, way}.
// One write port, one read port with registered read data. Depends on salc_pkg.
module salc_line_ram (
    input  logic                   clk,
    input  logic                   we,
    input  logic [salc_pkg::LINE_AW-1:0] waddr,
    input  salc_pkg::line_t        wdata,
    input  logic [salc_pkg::LINE_AW-1:0] raddr,
    output salc_pkg::line_t        rdata
);
    import salc_pkg::*;

    line_t mem [2**LINE_AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/set_assoc_lru_cache_model_core.sv
// Set-associative LRU cache classifier. A load or store goes from start to the done
// strobe through one read issue, one evaluation step per way in use and one fill;
// a modify makes two such passes; a fetch is taken and gives no result.
// The next start is taken in the cycle done is high. The ways of a set are walked
// one per cycle through the single read port of the line store.
// After reset, busy stays high while every entry of the line store is cleared.
module set_assoc_lru_cache_model_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] address,
    output logic        done,
    output logic [1:0]  outcome,
    output logic        second_hit,
    output logic [31:0] hit_count,
    output logic [31:0] miss_count,
    output logic [31:0] eviction_count
);
    import salc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_FILL
    } state_t;

    state_t                  state_reg;
    logic [3:0]              set_bits_reg;
    logic [4:0]              block_bits_reg;
    logic [3:0]              ways_reg;
    logic [LINE_AW-1:0]      clr_cnt_reg;
    logic [MAX_SET_BITS-1:0] set_reg;
    logic [31:0]             tag_reg;
    logic [NWAY_W-1:0]       nways_reg;
    logic [WAY_W-1:0]        way_reg;
    logic                    pass_reg;
    logic                    modify_reg;
    logic                    hit_reg;
    logic                    have_empty_reg;
    logic [WAY_W-1:0]        empty_way_reg;
    logic [WAY_W-1:0]        victim_reg;
    logic [31:0]             victim_age_reg;
    logic                    done_reg;
    logic [1:0]              outcome_reg;
    logic                    second_reg;
    logic [31:0]             hit_total_reg;
    logic [31:0]             miss_total_reg;
    logic [31:0]             evict_total_reg;

    logic                    mem_we;
    logic [LINE_AW-1:0]      mem_waddr;
    line_t                   mem_wdata;
    logic [LINE_AW-1:0]      mem_raddr;
    line_t                   rd_line;

    // address split from the live configuration
    logic [3:0]              s_eff;
    logic [5:0]              sb_sum;
    logic [31:0]             addr_shifted;
    logic [MAX_SET_BITS:0]   set_mask;
    logic [MAX_SET_BITS-1:0] set_idx;
    logic [31:0]             tag_val;
    logic [NWAY_W-1:0]       nways_eff;

    logic                    match;
    logic [31:0]             age_new;
    logic                    last_way;
    logic [WAY_W-1:0]        fill_way;

    salc_line_ram u_line_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_line)
    );

    always_comb
    begin
        s_eff        = (set_bits_reg > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_reg;
        sb_sum       = 6'(s_eff) + 6'(block_bits_reg);
        addr_shifted = address >> block_bits_reg;
        set_mask     = ((MAX_SET_BITS+1)'(1) << s_eff) - (MAX_SET_BITS+1)'(1);
        set_idx      = addr_shifted[MAX_SET_BITS-1:0] & set_mask[MAX_SET_BITS-1:0];
        tag_val      = (sb_sum >= 6'd32) ? 32'd0 : (address >> sb_sum);
        if (ways_reg == 4'd0)
        begin
            nways_eff = NWAY_W'(1);
        end
        else if (ways_reg > 4'(MAX_WAYS))
        begin
            nways_eff = NWAY_W'(MAX_WAYS);
        end
        else
        begin
            nways_eff = NWAY_W'(ways_reg);
        end
    end

    assign match    = rd_line.valid && (rd_line.tag == tag_reg);
    assign age_new  = match ? 32'd0 : sat_inc(rd_line.age);
    assign last_way = (NWAY_W'(way_reg) + NWAY_W'(1)) == nways_reg;
    assign fill_way = have_empty_reg ? empty_way_reg : victim_reg;

    // line store port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {set_reg, way_reg};
        mem_wdata = '{valid: 1'b1, tag: tag_reg, age: 32'd0};
        mem_raddr = {set_reg, way_reg + WAY_W'(1)};
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            S_RD:
            begin
                mem_raddr = {set_reg, WAY_W'(0)};
            end
            S_EVAL:
            begin
                // write back the aged or refreshed line; invalid lines stay as they are
                mem_we    = rd_line.valid;
                mem_wdata = '{valid: 1'b1, tag: rd_line.tag, age: age_new};
            end
            S_FILL:
            begin
                mem_we    = !hit_reg;
                mem_waddr = {set_reg, fill_way};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            set_bits_reg    <= 4'd4;
            block_bits_reg  <= 5'd4;
            ways_reg        <= 4'd1;
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            pass_reg        <= 1'b0;
            modify_reg      <= 1'b0;
            hit_reg         <= 1'b0;
            have_empty_reg  <= 1'b0;
            outcome_reg     <= OUT_HIT;
            second_reg      <= 1'b0;
        end
        else
        begin
            // strobe on the fill step that ends the transaction
            done_reg <= (state_reg == S_FILL) && (pass_reg || !modify_reg);

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_data[3:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                    CFG_WAYS:       ways_reg       <= cfg_data[3:0];
                    default:        ;
                endcase
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + LINE_AW'(1);
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    // a fetch transaction is taken and dropped
                    if (start && mode != MODE_FETCH)
                    begin
                        set_reg    <= set_idx;
                        tag_reg    <= tag_val;
                        nways_reg  <= nways_eff;
                        modify_reg <= (mode == MODE_MODIFY);
                        pass_reg   <= 1'b0;
                        state_reg  <= S_RD;
                    end
                end
                S_RD:
                begin
                    hit_reg        <= 1'b0;
                    have_empty_reg <= 1'b0;
                    victim_reg     <= '0;
                    victim_age_reg <= '0;
                    way_reg        <= '0;
                    state_reg      <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (match)
                    begin
                        hit_reg <= 1'b1;
                    end
                    else if (!rd_line.valid)
                    begin
                        have_empty_reg <= 1'b1;
                        empty_way_reg  <= way_reg;
                    end

                    // victim starts at way 0 whatever its state; a later way wins only if it is valid,
                    // does not match and has a strictly greater age
                    if (way_reg == '0)
                    begin
                        victim_reg     <= '0;
                        victim_age_reg <= rd_line.valid ? age_new : rd_line.age;
                    end
                    else if (rd_line.valid && !match && (victim_age_reg < age_new))
                    begin
                        victim_reg     <= way_reg;
                        victim_age_reg <= age_new;
                    end

                    if (last_way)
                    begin
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        way_reg <= way_reg + WAY_W'(1);
                    end
                end
                S_FILL:
                begin
                    if (hit_reg)
                    begin
                        hit_total_reg <= sat_inc(hit_total_reg);
                    end
                    else
                    begin
                        miss_total_reg <= sat_inc(miss_total_reg);
                        if (!have_empty_reg)
                        begin
                            evict_total_reg <= sat_inc(evict_total_reg);
                        end
                    end

                    if (!pass_reg)
                    begin
                        outcome_reg <= hit_reg ? OUT_HIT
                                     : (have_empty_reg ? OUT_MISS : OUT_EVICT);
                    end

                    if (!pass_reg && modify_reg)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        second_reg <= modify_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign outcome        = outcome_reg;
    assign second_hit     = second_reg;
    assign hit_count      = hit_total_reg;
    assign miss_count     = miss_total_reg;
    assign eviction_count = evict_total_reg;

`ifndef NO_ASSERTIONS
    a_done_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FILL))
        else $error("result strobe without a preceding fill step");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (outcome == OUT_HIT || outcome == OUT_MISS || outcome == OUT_EVICT))
        else $error("result carries an undefined outcome code");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("line store written while idle");

    a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (hit_count >= $past(hit_count)))
        else $error("hit total went backward");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for set_assoc_lru_cache_model_core: a directed table followed by
// random phases of accesses with set locality, checked against a shadow LRU cache.
// Depends on salc_pkg and the core RTL.
module tb;
    import salc_pkg::*;

    localparam int LINES        = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int SETTLE       = 2 * MAX_WAYS + 8;
    localparam int TARGET_ITEMS = 1200;

    localparam logic [1:0] CFG_SPARE  = 2'd3;
    localparam logic       ROW_ACCESS = 1'b0;
    localparam logic       ROW_WRITE  = 1'b1;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        second_hit;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } report_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  sel;       // mode, or register index for a write
        logic [31:0] value;     // address, or write data for a write
        logic        typed;
        report_t     want;
    } plan_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data  = '0;
    logic        start     = 1'b0;
    logic [1:0]  mode      = '0;
    logic [31:0] address   = '0;
    logic        busy;
    logic        done;
    logic [1:0]  outcome;
    logic        second_hit;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;

    // shadow copy of the line store, totals and registers
    logic        shadow_valid [LINES];
    logic [31:0] shadow_tag   [LINES];
    logic [31:0] shadow_age   [LINES];
    logic [31:0] shadow_hits      = '0;
    logic [31:0] shadow_misses    = '0;
    logic [31:0] shadow_evictions = '0;
    logic [3:0]  sh_set_bits   = 4'd4;
    logic [4:0]  sh_block_bits = 5'd4;
    logic [3:0]  sh_ways       = 4'd1;

    report_t pending_reports [$];
    int      fail_count = 0;

    set_assoc_lru_cache_model_core i_dut (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("set_assoc_lru_cache_model_core regression: fail");
        $finish;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == SAT32) ? v : v + 32'd1;
    endfunction

    // One pass over the ways in use of a set; updates ages, fills and totals.
    function automatic logic [1:0] probe_set(input int unsigned base, input logic [31:0] tag,
                                             input int unsigned nways);
        logic        hit;
        logic        have_empty;
        int unsigned fill_way;
        int unsigned victim;
        hit        = 1'b0;
        have_empty = 1'b0;
        fill_way   = 0;
        victim     = 0;
        for (int unsigned w = 0; w < nways; w++)
        begin
            if (shadow_valid[base + w] && shadow_tag[base + w] == tag)
            begin
                hit = 1'b1;
                shadow_age[base + w] = '0;
            end
            else if (!shadow_valid[base + w])
            begin
                have_empty = 1'b1;
                fill_way   = w;
            end
            else
            begin
                shadow_age[base + w] = bump(shadow_age[base + w]);
                if (shadow_age[base + victim] < shadow_age[base + w])
                    victim = w;
            end
        end
        if (hit)
        begin
            shadow_hits = bump(shadow_hits);
            return OUT_HIT;
        end
        shadow_misses = bump(shadow_misses);
        if (!have_empty)
        begin
            shadow_evictions = bump(shadow_evictions);
            fill_way = victim;
        end
        shadow_valid[base + fill_way] = 1'b1;
        shadow_tag[base + fill_way]   = tag;
        shadow_age[base + fill_way]   = '0;
        return have_empty ? OUT_MISS : OUT_EVICT;
    endfunction

    // Returns 1 when the access yields a report, filled into r.
    function automatic logic classify_access(input logic [1:0] m, input logic [31:0] a,
                                             output report_t r);
        int unsigned s;
        int unsigned b;
        int unsigned nw;
        int unsigned base;
        logic [31:0] set_idx;
        logic [31:0] tag;
        r = '0;
        if (m == MODE_FETCH)
            return 1'b0;
        s  = (sh_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : sh_set_bits;
        b  = sh_block_bits;
        nw = (sh_ways == 0) ? 1 : (sh_ways > MAX_WAYS) ? MAX_WAYS : sh_ways;
        set_idx = (a >> b) & ((32'd1 << s) - 32'd1);
        tag     = (s + b >= 32) ? '0 : (a >> (s + b));
        base    = set_idx * MAX_WAYS;
        r.outcome = probe_set(base, tag, nw);
        if (m == MODE_MODIFY)
        begin
            void'(probe_set(base, tag, nw));
            r.second_hit = 1'b1;
        end
        r.hits      = shadow_hits;
        r.misses    = shadow_misses;
        r.evictions = shadow_evictions;
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Drop start and wait until every report is in and the core is idle.
    task automatic settle();
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SET_BITS:   sh_set_bits   = data[3:0];
            CFG_BLOCK_BITS: sh_block_bits = data;
            CFG_WAYS:       sh_ways       = data[3:0];
            default:        ;
        endcase
    endtask

    // Hold start until the transaction is taken, then queue its report.
    task automatic issue(input logic [1:0] m, input logic [31:0] a, input logic typed,
                         input report_t want);
        report_t predicted;
        start   <= 1'b1;
        mode    <= m;
        address <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (classify_access(m, a, predicted))
            pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic pause(input int unsigned n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        report_t seen;
        report_t want;
        if (rst_n && done)
        begin
            seen = '{outcome, second_hit, hit_count, miss_count, eviction_count};
            if (pending_reports.size() == 0)
            begin
                $write("%0t: unexpected report outcome=%0d second=%0d",
                       $time, seen.outcome, seen.second_hit);
                $display(" hits=%0d misses=%0d evictions=%0d",
                         seen.hits, seen.misses, seen.evictions);
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (want !== seen)
                begin
                    $write("%0t: mismatch expected outcome=%0d second=%0d",
                           $time, want.outcome, want.second_hit);
                    $display(" hits=%0d misses=%0d evictions=%0d",
                             want.hits, want.misses, want.evictions);
                    $write("%0t:          actual   outcome=%0d second=%0d",
                           $time, seen.outcome, seen.second_hit);
                    $display(" hits=%0d misses=%0d evictions=%0d",
                             seen.hits, seen.misses, seen.evictions);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        plan_row_t   plan [$];
        logic [31:0] pool [24];
        logic [31:0] hot [3];
        int unsigned accesses;
        int unsigned phase_len;
        int unsigned pool_size;
        int unsigned hot_count;
        int unsigned pick;
        int unsigned s_eff;
        logic        quiet;
        logic [31:0] offset_mask;
        logic [31:0] set_mask;
        logic [31:0] addr;
        logic [1:0]  m;

        for (int i = 0; i < LINES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i]   = '0;
            shadow_age[i]   = '0;
        end

        // reset values: 16 sets, 16-byte blocks, one way
        plan.push_back('{ROW_ACCESS, MODE_LOAD, 32'h0000_0000, 1'b1,
                         '{OUT_MISS, 1'b0, 32'd0, 32'd1, 32'd0}});
        plan.push_back('{ROW_ACCESS, MODE_LOAD, 32'h0000_000C, 1'b1,
                         '{OUT_HIT, 1'b0, 32'd1, 32'd1, 32'd0}});
        plan.push_back('{ROW_ACCESS, MODE_FETCH, 32'h0000_0000, 1'b0, '0});
        plan.push_back('{ROW_ACCESS, MODE_STORE, 32'h0000_0100, 1'b1,
                         '{OUT_EVICT, 1'b0, 32'd1, 32'd2, 32'd1}});
        plan.push_back('{ROW_ACCESS, MODE_MODIFY, 32'h0000_0100, 1'b1,
                         '{OUT_HIT, 1'b1, 32'd3, 32'd2, 32'd1}});
        plan.push_back('{ROW_ACCESS, MODE_MODIFY, 32'hFFFF_FFFF, 1'b1,
                         '{OUT_MISS, 1'b1, 32'd4, 32'd3, 32'd1}});
        plan.push_back('{ROW_ACCESS, MODE_LOAD, 32'hFFFF_FFF0, 1'b1,
                         '{OUT_HIT, 1'b0, 32'd5, 32'd3, 32'd1}});
        // same tag left in two ways by shrinking and growing the ways in use
        plan.push_back('{ROW_WRITE, CFG_WAYS, 32'd2, 1'b0, '0});
        plan.push_back('{ROW_ACCESS, MODE_LOAD, 32'h0000_0A50, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_WAYS, 32'd1, 1'b0, '0});
        plan.push_back('{ROW_ACCESS, MODE_LOAD, 32'h0000_0A50, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_WAYS, 32'd2, 1'b0, '0});
        plan.push_back('{ROW_ACCESS, MODE_LOAD, 32'h0000_0A50, 1'b0, '0});
        // fill all eight ways of set 0, then evict by age
        plan.push_back('{ROW_WRITE, CFG_WAYS, 32'd8, 1'b0, '0});
        for (int k = 2; k <= 10; k++)
            plan.push_back('{ROW_ACCESS, (k % 3 == 0) ? MODE_MODIFY : MODE_LOAD,
                             32'(k) << 8, 1'b0, '0});
        // set bits above the maximum, and a tag shift past the address width
        plan.push_back('{ROW_WRITE, CFG_SET_BITS, 32'd15, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_BLOCK_BITS, 32'd31, 1'b0, '0});
        plan.push_back('{ROW_ACCESS, MODE_LOAD, 32'hDEAD_BEEF, 1'b0, '0});
        plan.push_back('{ROW_ACCESS, MODE_STORE, 32'h1234_5678, 1'b0, '0});
        // ways of zero once masked, then a single set with no offset
        plan.push_back('{ROW_WRITE, CFG_WAYS, 32'd16, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SET_BITS, 32'd0, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_BLOCK_BITS, 32'd0, 1'b0, '0});
        plan.push_back('{ROW_ACCESS, MODE_MODIFY, 32'h0000_0000, 1'b0, '0});
        plan.push_back('{ROW_ACCESS, MODE_LOAD, 32'hFFFF_FFFF, 1'b0, '0});
        plan.push_back('{ROW_WRITE, CFG_SPARE, 32'd31, 1'b0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].sel, plan[i].value[4:0]);
            else
            begin
                issue(plan[i].sel, plan[i].value, plan[i].typed, plan[i].want);
                pause(pick_gap());
            end
        end

        accesses = 0;
        while (accesses < TARGET_ITEMS)
        begin
            write_reg(CFG_SET_BITS, ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 8))
                                                                : 5'($urandom_range(0, 31)));
            write_reg(CFG_BLOCK_BITS, ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 12))
                                                                  : 5'($urandom_range(0, 31)));
            write_reg(CFG_WAYS, ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 8))
                                                            : 5'($urandom_range(0, 31)));

            // crowd the pool into a few sets so replacement gets exercised
            s_eff       = (sh_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : sh_set_bits;
            offset_mask = (32'd1 << sh_block_bits) - 32'd1;
            set_mask    = ((32'd1 << s_eff) - 32'd1) << sh_block_bits;
            hot_count   = $urandom_range(1, 3);
            for (int j = 0; j < 3; j++)
                hot[j] = $urandom;
            pool_size = $urandom_range(2, 24);
            for (int k = 0; k < 24; k++)
                pool[k] = ($urandom & ~set_mask) | (hot[k % hot_count] & set_mask);
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 140);

            for (int unsigned n = 0; n < phase_len; n++)
            begin
                pick = $urandom_range(0, 9);
                m = (pick < 4) ? MODE_LOAD :
                    (pick < 6) ? MODE_STORE :
                    (pick < 8) ? MODE_MODIFY :
                    (pick == 8) ? MODE_FETCH : MODE_LOAD;
                if ($urandom_range(0, 99) < 85)
                    addr = pool[$urandom_range(0, pool_size - 1)] ^ ($urandom & offset_mask);
                else
                    addr = $urandom;
                issue(m, addr, 1'b0, '0);
                accesses++;
                if (!quiet)
                    pause(pick_gap());
            end
        end

        settle();
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("set_assoc_lru_cache_model_core regression: pass");
        else
            $display("set_assoc_lru_cache_model_core regression: fail");
        $finish;
    end

endmodule

FILE: files.f
design/salc_pkg.sv
design/salc_line_ram.sv
design/set_assoc_lru_cache_model_core.sv
bench/tb.sv
